// File: hw/rtl/ebt_pkg.sv
// ----------------------------------------------------------------------------
// ebt_pkg
// Shared widths, constants, register indexes and unit interface types for
// the energy budget tracker.
// ----------------------------------------------------------------------------
package ebt_pkg;

    // Field and datapath widths
    localparam int CNT_W   = 32;               // activity counter width
    localparam int WGT_W   = 32;               // per-tick weight width
    localparam int ACC_W   = 48;               // energy accumulator width
    localparam int FRAC_W  = 32;               // fraction bits of one mJ
    localparam int CAP_W   = 16;               // capacity in mJ
    localparam int THR_W   = 7;                // threshold in percent
    localparam int PCT_W   = 10;               // percent in tenths
    localparam int OPD_W   = 32;               // multiplier operand width
    localparam int PROD_W  = 2 * OPD_W;        // multiplier product width
    localparam int TCAP_W  = THR_W + CAP_W;    // threshold times capacity
    localparam int P100_W  = ACC_W + THR_W;    // energy times one hundred
    localparam int LO100_W = FRAC_W + THR_W;   // low half times one hundred
    localparam int NUM_W   = 26;               // (energy * 1000) >> FRAC_W
    localparam int QUO_W   = 11;               // divider quotient bits
    localparam int REM_W   = CAP_W;            // divider remainder width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int NUM_CNT = 4;                // activity counters per beat
    localparam int NUM_THR = 3;                // alert levels

    localparam logic [ACC_W-1:0]  ACC_MAX      = '1;
    localparam logic [PCT_W-1:0]  PCT_FULL     = 10'd1000;
    localparam logic [QUO_W-1:0]  QUO_FULL     = 11'd1000;
    localparam logic [OPD_W-1:0]  SCALE_PCT    = 32'd100;

    // Reset values of the registers
    localparam logic [WGT_W-1:0]  WEIGHT_CPU_RST    = 32'd65536;
    localparam logic [WGT_W-1:0]  WEIGHT_LP_RST     = 32'd66;
    localparam logic [WGT_W-1:0]  WEIGHT_TX_RST     = 32'd2280653;
    localparam logic [WGT_W-1:0]  WEIGHT_RX_RST     = 32'd2464154;
    localparam logic [CAP_W-1:0]  CAPACITY_RST      = 16'd8800;
    localparam logic [THR_W-1:0]  THR_LOW_RST       = 7'd20;
    localparam logic [THR_W-1:0]  THR_CRITICAL_RST  = 7'd10;
    localparam logic [THR_W-1:0]  THR_URGENT_RST    = 7'd5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_CPU       = 3'd0,
        REG_WEIGHT_LOW_POWER = 3'd1,
        REG_WEIGHT_TRANSMIT  = 3'd2,
        REG_WEIGHT_LISTEN    = 3'd3,
        REG_CAPACITY_MJ      = 3'd4,
        REG_THR_LOW          = 3'd5,
        REG_THR_CRITICAL     = 3'd6,
        REG_THR_URGENT       = 3'd7
    } t_reg_idx;

    // What a multiplier product is used for
    typedef enum logic [1:0] {
        TAG_WEIGHT  = 2'd0,
        TAG_THRESH  = 2'd1,
        TAG_E100_LO = 2'd2,
        TAG_E100_HI = 2'd3
    } t_mul_tag;

    typedef struct packed {
        logic             valid;
        t_mul_tag         tag;
        logic [1:0]       idx;
        logic [OPD_W-1:0] a;
        logic [OPD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              valid;
        t_mul_tag          tag;
        logic [1:0]        idx;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [CAP_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: hw/rtl/energy_budget_tracker_core.sv
// ----------------------------------------------------------------------------
// energy_budget_tracker_core
// Weighted activity energy accumulator with percent readout, depletion
// event and three one-time threshold alerts.
// ----------------------------------------------------------------------------
// Usage:
//  Slave stream: one beat carries four cumulative tick counters (cpu, low
//  power, transmit, listen). The block takes wrapping deltas against the
//  previous beat, weights them, subtracts the energy from the remaining
//  budget and returns one master beat per input beat.
//  Config channel: write register index and data while the block is idle;
//  writing the capacity reloads the remaining energy to full.
//  Sequence: each beat takes seven passes through the shared 32x32
//  multiplier (four weights, three thresholds), two more for energy
//  times one hundred, and the 11-step divider that forms the percent in
//  tenths.
//  s_axis_tready is high only while no beat is in work.
//  Reset: weights, capacity and thresholds take their default values, the
//  stored counters clear and the budget reloads to full capacity.
//  Stall: a finished result waits in the output register; the next input
//  beat is taken meanwhile, and its result holds until the first is taken.
// ----------------------------------------------------------------------------
module energy_budget_tracker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input beat: cpu_ticks, low_power_ticks, transmit_ticks, listen_ticks
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [127:0]                  s_axis_tdata,
    // Result beat: energy left, energy spent, percent in tenths, zero pad
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [111:0]                  m_axis_tdata,
    // Flags: depleted_now, depleted, alert_low, alert_critical, alert_urgent
    output logic [4:0]                    m_axis_tuser,
    // Register write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ebt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ebt_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_WMUL = 9'b000000010,
        ST_TMUL = 9'b000000100,
        ST_SUB  = 9'b000001000,
        ST_EMUL = 9'b000010000,
        ST_EFIN = 9'b000100000,
        ST_EVAL = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    localparam int CW = ebt_pkg::CNT_W;
    localparam int AW = ebt_pkg::ACC_W;

    // Configuration registers
    logic [ebt_pkg::WGT_W-1:0] r_weight [ebt_pkg::NUM_CNT];
    logic [ebt_pkg::CAP_W-1:0] r_cap;
    logic [ebt_pkg::THR_W-1:0] r_thr    [ebt_pkg::NUM_THR];

    // Tracking state
    logic [CW-1:0]             r_last   [ebt_pkg::NUM_CNT];
    logic [CW-1:0]             r_delta  [ebt_pkg::NUM_CNT];
    logic [AW-1:0]             r_energy;
    logic                      r_exh;
    logic [ebt_pkg::NUM_THR-1:0] r_aflag;

    // Per-beat working registers
    logic [AW-1:0]               r_used;
    logic [ebt_pkg::TCAP_W-1:0]  r_tcap  [ebt_pkg::NUM_THR];
    logic [ebt_pkg::LO100_W-1:0] r_lo100;
    logic [ebt_pkg::P100_W-1:0]  r_p100;
    logic [ebt_pkg::PCT_W-1:0]   r_tenths;
    logic                        r_now;
    logic [ebt_pkg::NUM_THR-1:0] r_pulse;

    // Sequencer
    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;

    // Output register
    logic         r_m_valid;
    logic [111:0] r_m_data;
    logic [4:0]   r_m_user;

    // Unit interfaces
    ebt_pkg::t_mul_req w_mreq;
    ebt_pkg::t_mul_rsp w_mrsp;
    ebt_pkg::t_div_req w_dreq;
    ebt_pkg::t_div_rsp w_drsp;

    logic          w_in_acc;
    logic          w_cfg_acc;
    logic [AW-1:0] w_wsat;
    logic [AW:0]   w_sum;
    logic [ebt_pkg::P100_W+3:0] w_p1000;
    logic [ebt_pkg::NUM_THR-1:0] w_hit;
    logic          w_out_load;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_load = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    // ------------------------------------------------------------------
    // Shared multiplier and divider
    // ------------------------------------------------------------------
    ebt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    ebt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // Issue one multiply per cycle from the sequencer
    always_comb begin
        w_mreq       = '0;
        w_mreq.tag   = ebt_pkg::TAG_WEIGHT;
        w_mreq.idx   = r_cnt;
        case (r_state)
            ST_WMUL: begin
                w_mreq.valid = 1'b1;
                w_mreq.tag   = ebt_pkg::TAG_WEIGHT;
                w_mreq.a     = r_delta[r_cnt];
                w_mreq.b     = r_weight[r_cnt];
            end
            ST_TMUL: begin
                w_mreq.valid = 1'b1;
                w_mreq.tag   = ebt_pkg::TAG_THRESH;
                w_mreq.a     = {{(ebt_pkg::OPD_W - ebt_pkg::THR_W){1'b0}},
                                (r_cnt == 2'd0) ? r_thr[0] :
                                (r_cnt == 2'd1) ? r_thr[1] : r_thr[2]};
                w_mreq.b     = {{(ebt_pkg::OPD_W - ebt_pkg::CAP_W){1'b0}}, r_cap};
            end
            ST_EMUL: begin
                w_mreq.valid = 1'b1;
                w_mreq.b     = ebt_pkg::SCALE_PCT;
                if (r_cnt == 2'd0) begin
                    w_mreq.tag = ebt_pkg::TAG_E100_LO;
                    w_mreq.a   = r_energy[ebt_pkg::FRAC_W-1:0];
                end else begin
                    w_mreq.tag = ebt_pkg::TAG_E100_HI;
                    w_mreq.a   = {{(ebt_pkg::OPD_W - (AW - ebt_pkg::FRAC_W)){1'b0}},
                                  r_energy[AW-1:ebt_pkg::FRAC_W]};
                end
            end
            default: begin
                w_mreq.valid = 1'b0;
            end
        endcase
    end

    // Saturate each weighted delta and the running sum to 48 bits
    assign w_wsat = (w_mrsp.prod[ebt_pkg::PROD_W-1:AW] != '0) ? ebt_pkg::ACC_MAX
                                                             : w_mrsp.prod[AW-1:0];
    assign w_sum  = {1'b0, r_used} + {1'b0, w_wsat};

    // Energy times 1000 from energy times 100: x*8 + x*2
    assign w_p1000 = {1'b0, r_p100, 3'b000} + {3'b000, r_p100, 1'b0};

    // Alert compares: 100*remaining <= threshold*capacity << FRAC_W
    always_comb begin
        for (int i = 0; i < ebt_pkg::NUM_THR; i++) begin
            w_hit[i] = (r_p100 <= {r_tcap[i], {ebt_pkg::FRAC_W{1'b0}}});
        end
    end

    assign w_dreq.start = (r_state == ST_EVAL);
    assign w_dreq.num   = w_p1000[ebt_pkg::FRAC_W +: ebt_pkg::NUM_W];
    assign w_dreq.den   = r_cap;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = 2'd0;
                if (w_in_acc) begin
                    n_state = ST_WMUL;
                end
            end
            ST_WMUL: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'(ebt_pkg::NUM_CNT - 1)) begin
                    n_state = ST_TMUL;
                    n_cnt   = 2'd0;
                end
            end
            ST_TMUL: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'(ebt_pkg::NUM_THR - 1)) begin
                    n_state = ST_SUB;
                    n_cnt   = 2'd0;
                end
            end
            ST_SUB: begin
                n_state = ST_EMUL;
                n_cnt   = 2'd0;
            end
            ST_EMUL: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd1) begin
                    n_state = ST_EFIN;
                end
            end
            ST_EFIN: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_drsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Configuration and tracking state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight[0] <= ebt_pkg::WEIGHT_CPU_RST;
            r_weight[1] <= ebt_pkg::WEIGHT_LP_RST;
            r_weight[2] <= ebt_pkg::WEIGHT_TX_RST;
            r_weight[3] <= ebt_pkg::WEIGHT_RX_RST;
            r_cap       <= ebt_pkg::CAPACITY_RST;
            r_thr[0]    <= ebt_pkg::THR_LOW_RST;
            r_thr[1]    <= ebt_pkg::THR_CRITICAL_RST;
            r_thr[2]    <= ebt_pkg::THR_URGENT_RST;
            r_energy    <= {ebt_pkg::CAPACITY_RST, {ebt_pkg::FRAC_W{1'b0}}};
            r_exh       <= 1'b0;
            r_aflag     <= '0;
            for (int i = 0; i < ebt_pkg::NUM_CNT; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            // Register writes; a capacity write reloads the budget
            if (w_cfg_acc) begin
                case (ebt_pkg::t_reg_idx'(i_cfg_index))
                    ebt_pkg::REG_WEIGHT_CPU:       r_weight[0] <= i_cfg_data;
                    ebt_pkg::REG_WEIGHT_LOW_POWER: r_weight[1] <= i_cfg_data;
                    ebt_pkg::REG_WEIGHT_TRANSMIT:  r_weight[2] <= i_cfg_data;
                    ebt_pkg::REG_WEIGHT_LISTEN:    r_weight[3] <= i_cfg_data;
                    ebt_pkg::REG_CAPACITY_MJ: begin
                        r_cap    <= i_cfg_data[ebt_pkg::CAP_W-1:0];
                        r_energy <= {i_cfg_data[ebt_pkg::CAP_W-1:0],
                                     {ebt_pkg::FRAC_W{1'b0}}};
                    end
                    ebt_pkg::REG_THR_LOW:      r_thr[0] <= i_cfg_data[ebt_pkg::THR_W-1:0];
                    ebt_pkg::REG_THR_CRITICAL: r_thr[1] <= i_cfg_data[ebt_pkg::THR_W-1:0];
                    ebt_pkg::REG_THR_URGENT:   r_thr[2] <= i_cfg_data[ebt_pkg::THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            // Store the new sample
            if (w_in_acc) begin
                for (int i = 0; i < ebt_pkg::NUM_CNT; i++) begin
                    r_last[i] <= s_axis_tdata[i*CW +: CW];
                end
            end
            // Take the energy from the budget, floor at zero
            if (r_state == ST_SUB) begin
                r_energy <= (r_used >= r_energy) ? '0 : r_energy - r_used;
            end
            // Depletion first, alerts only while not depleted
            if (r_state == ST_EVAL) begin
                if ((r_energy == '0) && !r_exh) begin
                    r_exh <= 1'b1;
                end else if (!r_exh) begin
                    r_aflag <= r_aflag | w_hit;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-beat datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // Wrapping deltas against the previous sample
        if (w_in_acc) begin
            for (int i = 0; i < ebt_pkg::NUM_CNT; i++) begin
                r_delta[i] <= s_axis_tdata[i*CW +: CW] - r_last[i];
            end
            r_used <= '0;
        end
        // Collect products by tag
        if (w_mrsp.valid) begin
            case (w_mrsp.tag)
                ebt_pkg::TAG_WEIGHT: begin
                    r_used <= w_sum[AW] ? ebt_pkg::ACC_MAX : w_sum[AW-1:0];
                end
                ebt_pkg::TAG_THRESH: begin
                    r_tcap[w_mrsp.idx] <= w_mrsp.prod[ebt_pkg::TCAP_W-1:0];
                end
                ebt_pkg::TAG_E100_LO: begin
                    r_lo100 <= w_mrsp.prod[ebt_pkg::LO100_W-1:0];
                end
                ebt_pkg::TAG_E100_HI: begin
                    r_p100 <= {w_mrsp.prod[ebt_pkg::TCAP_W-1:0], {ebt_pkg::FRAC_W{1'b0}}}
                              + {{(ebt_pkg::P100_W - ebt_pkg::LO100_W){1'b0}}, r_lo100};
                end
                default: begin
                end
            endcase
        end
        // Event pulses for this beat
        if (r_state == ST_EVAL) begin
            r_now   <= (r_energy == '0) && !r_exh;
            r_pulse <= ((r_energy != '0) && !r_exh) ? (w_hit & ~r_aflag) : '0;
        end
        if (w_drsp.done) begin
            r_tenths <= w_drsp.quot;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {6'b000000, r_tenths, r_used, r_energy};
            r_m_user <= {r_pulse[2], r_pulse[1], r_pulse[0], r_exh, r_now};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef SYNTH
    // Accepted beat starts the weight passes
    a_start_wmul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_WMUL))
        else $error("accepted beat did not start the weight passes");

    // Depletion flag never clears
    a_exh_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exh |=> r_exh)
        else $error("depletion flag cleared");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> (r_state == ST_DIV))
        else $error("divider done outside its wait state");

    // No alert on the depletion beat
    a_no_alert_on_depl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[4:2] == 3'b000))
        else $error("alert raised on depletion beat");
`endif

endmodule

// File: hw/rtl/ebt_mul.sv
// ----------------------------------------------------------------------------
// ebt_mul
// Shared 32x32 multiplier with a registered product; the tag and index of
// each request travel with the product.
// ----------------------------------------------------------------------------
module ebt_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ebt_pkg::t_mul_req i_req,
    output ebt_pkg::t_mul_rsp o_rsp
);

    logic                       r_valid;
    ebt_pkg::t_mul_tag          r_tag;
    logic [1:0]                 r_idx;
    logic [ebt_pkg::PROD_W-1:0] r_prod;

    // Track which product is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.valid;
        end
    end

    // Multiply and hold the product
    always_ff @(posedge i_clk) begin
        r_tag  <= i_req.tag;
        r_idx  <= i_req.idx;
        r_prod <= {{ebt_pkg::OPD_W{1'b0}}, i_req.a} * {{ebt_pkg::OPD_W{1'b0}}, i_req.b};
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.tag   = r_tag;
    assign o_rsp.idx   = r_idx;
    assign o_rsp.prod  = r_prod;

endmodule

// File: hw/rtl/ebt_div.sv
// ----------------------------------------------------------------------------
// ebt_div
// Restoring divider, one quotient bit per cycle, for the percent readout:
// quotient of a 26-bit numerator by the 16-bit capacity, clamped to 1000.
// ----------------------------------------------------------------------------
module ebt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ebt_pkg::t_div_req i_req,
    output ebt_pkg::t_div_rsp o_rsp
);

    localparam int LOW_W = ebt_pkg::QUO_W;
    localparam int HI_W  = ebt_pkg::NUM_W - LOW_W;

    logic                        r_busy;
    logic                        r_done;
    logic [3:0]                  r_cnt;
    logic [ebt_pkg::REM_W-1:0]   r_rem;
    logic [LOW_W-1:0]            r_num;
    logic [ebt_pkg::QUO_W-1:0]   r_quo;
    logic [ebt_pkg::CAP_W-1:0]   r_den;
    logic                        r_den_zero;
    logic                        r_ovf;

    logic [ebt_pkg::REM_W:0]     w_trial;
    logic                        w_fit;

    // Trial subtract for the next quotient bit
    assign w_trial = {r_rem, r_num[LOW_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // Control: busy over the quotient bits, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(LOW_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem      <= {{(ebt_pkg::REM_W - HI_W){1'b0}}, i_req.num[ebt_pkg::NUM_W-1:LOW_W]};
            r_num      <= i_req.num[LOW_W-1:0];
            r_quo      <= '0;
            r_den      <= i_req.den;
            r_den_zero <= (i_req.den == '0);
            r_ovf      <= ({1'b0, i_req.num[ebt_pkg::NUM_W-1:LOW_W]} >= i_req.den);
        end else if (r_busy) begin
            r_rem <= w_fit ? ebt_pkg::REM_W'(w_trial - {1'b0, r_den})
                           : w_trial[ebt_pkg::REM_W-1:0];
            r_num <= {r_num[LOW_W-2:0], 1'b0};
            r_quo <= {r_quo[ebt_pkg::QUO_W-2:0], w_fit};
        end
    end

    // Clamp the readout
    always_comb begin
        if (r_den_zero) begin
            o_rsp.quot = '0;
        end else if (r_ovf || (r_quo > ebt_pkg::QUO_FULL)) begin
            o_rsp.quot = ebt_pkg::PCT_FULL;
        end else begin
            o_rsp.quot = r_quo[ebt_pkg::PCT_W-1:0];
        end
    end

    assign o_rsp.done = r_done;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for energy_budget_tracker_core. A directed plan walks
// reset values, zero and full-scale weights, counter wrap, thresholds above
// one hundred percent, depletion, 48-bit saturation and zero capacity. After
// that, randomized phases rewrite every register and stream cumulative tick
// samples. Each result beat is checked against a cycle-free budget model
// or a fixed beat. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ebt_pkg::*;

    localparam int SAMPLE_TARGET = 450;
    localparam int PHASES        = 8;
    localparam int NUM_REGS      = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [63:0]      SAT48        = {16'd0, ACC_MAX};
    localparam logic [ACC_W-1:0] FULL_RESET   = {CAPACITY_RST, 32'd0};
    localparam logic [4:0]       FLG_NONE     = 5'b00000;
    localparam logic [4:0]       FLG_DEPLETED = 5'b00010;

    // Four cumulative counters, cpu in the low word
    typedef logic [NUM_CNT-1:0][CNT_W-1:0] tick_set_t;

    localparam tick_set_t TICKS_ZERO = '0;
    localparam tick_set_t TICKS_ONES = '1;

    typedef struct packed {
        logic [ACC_W-1:0] remaining;
        logic [ACC_W-1:0] used;
        logic [PCT_W-1:0] tenths;
        logic [4:0]       flags;     // now, depleted, low, critical, urgent
    } energy_beat_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_e;

    typedef struct {
        row_kind_e    kind;
        t_reg_idx     idx;
        logic [31:0]  data;
        tick_set_t    ticks;
        bit           known;
        energy_beat_t want;
    } plan_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [111:0]         m_axis_tdata;
    logic [4:0]           m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // Budget model state and its copy of the registers
    logic [CNT_W-1:0]   prev_ticks  [NUM_CNT];
    logic [WGT_W-1:0]   tick_weight [NUM_CNT];
    logic [THR_W-1:0]   alert_pct   [NUM_THR];
    logic [CAP_W-1:0]   cap_mj;
    logic [ACC_W-1:0]   left_energy;
    logic               is_depleted;
    logic [NUM_THR-1:0] alerts_fired;

    energy_beat_t pending_budget_q[$];
    energy_beat_t seen_beat;
    energy_beat_t due_beat;
    int           mismatch_cnt = 0;
    int           beat_no      = 0;
    int           rx_cycle     = 0;
    int           rx_hold      = 0;

    energy_budget_tracker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic energy_beat_t make_beat(input logic [ACC_W-1:0] remaining,
                                               input logic [ACC_W-1:0] used,
                                               input logic [PCT_W-1:0] tenths,
                                               input logic [4:0]       flags);
        energy_beat_t b;
        b.remaining = remaining;
        b.used      = used;
        b.tenths    = tenths;
        b.flags     = flags;
        return b;
    endfunction

    function automatic plan_row_t write_row(input t_reg_idx idx, input logic [31:0] data);
        plan_row_t r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.data  = data;
        r.ticks = '0;
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic plan_row_t sample_row(input tick_set_t ticks, input bit known,
                                             input energy_beat_t want);
        plan_row_t r;
        r.kind  = ROW_SAMPLE;
        r.idx   = REG_WEIGHT_CPU;
        r.data  = '0;
        r.ticks = ticks;
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    // Apply one register write to the model
    function automatic void budget_write(input t_reg_idx idx, input logic [31:0] data);
        case (idx)
            REG_WEIGHT_CPU:       tick_weight[0] = data;
            REG_WEIGHT_LOW_POWER: tick_weight[1] = data;
            REG_WEIGHT_TRANSMIT:  tick_weight[2] = data;
            REG_WEIGHT_LISTEN:    tick_weight[3] = data;
            REG_CAPACITY_MJ: begin
                cap_mj      = data[CAP_W-1:0];
                left_energy = {cap_mj, 32'd0};
            end
            REG_THR_LOW:          alert_pct[0] = data[THR_W-1:0];
            REG_THR_CRITICAL:     alert_pct[1] = data[THR_W-1:0];
            REG_THR_URGENT:       alert_pct[2] = data[THR_W-1:0];
            default: ;
        endcase
    endfunction

    // Charge one counter sample against the budget and form its result beat
    function automatic energy_beat_t budget_step(input tick_set_t ticks);
        logic [63:0]        full;
        logic [63:0]        used;
        logic [63:0]        part;
        logic [63:0]        room;
        logic [63:0]        tenths;
        logic [63:0]        scaled;
        logic [63:0]        limit;
        logic [CNT_W-1:0]   delta;
        logic               now;
        logic [NUM_THR-1:0] pulses;
        int                 k;
        full = {16'd0, cap_mj, 32'd0};
        if (full > SAT48) full = SAT48;
        used = '0;
        // Wrapping deltas, each weighted and saturated at 48 bits
        for (k = 0; k < NUM_CNT; k++) begin
            delta = ticks[k] - prev_ticks[k];
            prev_ticks[k] = ticks[k];
            part = {32'd0, delta} * {32'd0, tick_weight[k]};
            if (part > SAT48) part = SAT48;
            used = used + part;
            if (used > SAT48) used = SAT48;
        end
        room = {16'd0, left_energy};
        room = (used >= room) ? 64'd0 : room - used;
        left_energy = room[ACC_W-1:0];
        tenths = '0;
        if (full != 0) begin
            tenths = (room * 64'd1000) / full;
            if (tenths > 64'd1000) tenths = 64'd1000;
        end
        // Depletion takes precedence; alerts only while still alive
        now    = 1'b0;
        pulses = '0;
        if (room == 0 && !is_depleted) begin
            is_depleted = 1'b1;
            now         = 1'b1;
        end else if (!is_depleted) begin
            for (k = 0; k < NUM_THR; k++) begin
                scaled = room * 64'd100;
                limit  = {57'd0, alert_pct[k]} * full;
                if (!alerts_fired[k] && scaled <= limit) begin
                    alerts_fired[k] = 1'b1;
                    pulses[k]       = 1'b1;
                end
            end
        end
        return make_beat(room[ACC_W-1:0], used[ACC_W-1:0], tenths[PCT_W-1:0],
                         {pulses, is_depleted, now});
    endfunction

    // Register write beat; valid stays high for a following write
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        budget_write(idx, data);
        @(negedge i_clk);
    endtask

    // Sample beat; valid stays high so back-to-back beats need no re-raise
    task automatic send_sample(input tick_set_t ticks, input bit known,
                               input energy_beat_t want);
        energy_beat_t modeled;
        s_axis_tdata  <= ticks;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        modeled = budget_step(ticks);
        pending_budget_q.push_back(known ? want : modeled);
        @(negedge i_clk);
    endtask

    // Hold the sender until every pending result beat is out
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_budget_q.size() != 0);
    endtask

    // Receiver: free-running, random per cycle, then long stalls, in turn
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            case (rx_cycle[10:9])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: begin
                    m_axis_tready <= !m_axis_tready;
                    rx_hold <= m_axis_tready ? $urandom_range(5, 40) : $urandom_range(0, 4);
                end
            endcase
        end
    end

    // Check each result beat against the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_beat = make_beat(m_axis_tdata[47:0], m_axis_tdata[95:48],
                                  m_axis_tdata[105:96], m_axis_tuser);
            if (pending_budget_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("%0t beat %0d unexpected: rem=%h used=%h pct=%0d flags=%b",
                             $time, beat_no, seen_beat.remaining, seen_beat.used,
                             seen_beat.tenths, seen_beat.flags);
            end else begin
                due_beat = pending_budget_q.pop_front();
                if (seen_beat.remaining !== due_beat.remaining ||
                    seen_beat.used      !== due_beat.used      ||
                    seen_beat.tenths    !== due_beat.tenths    ||
                    seen_beat.flags     !== due_beat.flags) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT) begin
                        $display("%0t beat %0d exp: rem=%h used=%h pct=%0d flags=%b",
                                 $time, beat_no, due_beat.remaining, due_beat.used,
                                 due_beat.tenths, due_beat.flags);
                        $display("%0t beat %0d got: rem=%h used=%h pct=%0d flags=%b",
                                 $time, beat_no, seen_beat.remaining, seen_beat.used,
                                 seen_beat.tenths, seen_beat.flags);
                    end
                end
            end
            beat_no++;
        end
    end

    initial begin : stimulus
        plan_row_t    plan_q[$];
        energy_beat_t full_idle;
        tick_set_t    run_ticks;
        t_reg_idx     reg_idx;
        logic [31:0]  reg_data;
        bit           writing;
        int           burst_left;
        int           n_items;
        int           step_max;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;

        // Model state after reset
        tick_weight[0] = WEIGHT_CPU_RST;
        tick_weight[1] = WEIGHT_LP_RST;
        tick_weight[2] = WEIGHT_TX_RST;
        tick_weight[3] = WEIGHT_RX_RST;
        cap_mj         = CAPACITY_RST;
        alert_pct[0]   = THR_LOW_RST;
        alert_pct[1]   = THR_CRITICAL_RST;
        alert_pct[2]   = THR_URGENT_RST;
        for (int k = 0; k < NUM_CNT; k++) prev_ticks[k] = '0;
        left_energy    = FULL_RESET;
        is_depleted    = 1'b0;
        alerts_fired   = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed plan: reset state, zero weights, wrap, alerts, depletion,
        // saturation, zero capacity, masked register bits
        full_idle = make_beat(FULL_RESET, '0, PCT_FULL, FLG_NONE);
        plan_q.push_back(sample_row(TICKS_ZERO, 1'b1, full_idle));
        plan_q.push_back(write_row(REG_WEIGHT_CPU, 32'd0));
        plan_q.push_back(write_row(REG_WEIGHT_LOW_POWER, 32'd0));
        plan_q.push_back(write_row(REG_WEIGHT_TRANSMIT, 32'd0));
        plan_q.push_back(write_row(REG_WEIGHT_LISTEN, 32'd0));
        plan_q.push_back(sample_row(TICKS_ONES, 1'b1, full_idle));
        plan_q.push_back(sample_row(TICKS_ZERO, 1'b1, full_idle));
        plan_q.push_back(write_row(REG_THR_LOW, 32'd127));
        plan_q.push_back(sample_row(TICKS_ZERO, 1'b0, '0));
        plan_q.push_back(write_row(REG_THR_CRITICAL, 32'd100));
        plan_q.push_back(write_row(REG_WEIGHT_CPU, 32'd1));
        plan_q.push_back(sample_row({96'd0, 32'd1}, 1'b0, '0));
        plan_q.push_back(write_row(REG_CAPACITY_MJ, 32'd1));
        plan_q.push_back(write_row(REG_WEIGHT_CPU, 32'hFFFF_FFFF));
        plan_q.push_back(write_row(REG_THR_URGENT, 32'd50));
        plan_q.push_back(sample_row({96'd0, 32'd2}, 1'b0, '0));
        plan_q.push_back(sample_row({96'd0, 32'd3}, 1'b0, '0));
        plan_q.push_back(sample_row({96'd0, 32'd4}, 1'b0, '0));
        plan_q.push_back(write_row(REG_CAPACITY_MJ, 32'd65535));
        plan_q.push_back(write_row(REG_WEIGHT_LOW_POWER, 32'hFFFF_FFFF));
        plan_q.push_back(write_row(REG_WEIGHT_TRANSMIT, 32'hFFFF_FFFF));
        plan_q.push_back(write_row(REG_WEIGHT_LISTEN, 32'hFFFF_FFFF));
        plan_q.push_back(sample_row({96'd0, 32'd5}, 1'b0, '0));
        plan_q.push_back(sample_row(TICKS_ONES, 1'b1,
                                    make_beat('0, ACC_MAX, '0, FLG_DEPLETED)));
        plan_q.push_back(write_row(REG_CAPACITY_MJ, 32'd0));
        plan_q.push_back(sample_row(TICKS_ONES, 1'b1,
                                    make_beat('0, '0, '0, FLG_DEPLETED)));
        plan_q.push_back(write_row(REG_CAPACITY_MJ, 32'hFFFF_0064));
        plan_q.push_back(write_row(REG_THR_LOW, 32'hFFFF_FF80));
        plan_q.push_back(write_row(REG_WEIGHT_CPU, 32'd65536));
        plan_q.push_back(sample_row({{3{32'hFFFF_FFFF}}, 32'd1000}, 1'b0, '0));

        // Walk the plan; writes go in only once the block is idle
        writing   = 1'b0;
        run_ticks = '0;
        foreach (plan_q[r]) begin
            if (plan_q[r].kind == ROW_WRITE) begin
                if (!writing) wait_results_drained();
                write_reg(plan_q[r].idx, plan_q[r].data);
                writing = 1'b1;
            end else begin
                if (writing) i_cfg_valid <= 1'b0;
                writing = 1'b0;
                send_sample(plan_q[r].ticks, plan_q[r].known, plan_q[r].want);
                run_ticks = plan_q[r].ticks;
            end
        end

        // Random phases: fresh registers, then bursts of counter samples
        burst_left = $urandom_range(1, 12);
        for (int p = 0; p < PHASES; p++) begin
            wait_results_drained();
            for (int k = 0; k < NUM_REGS; k++) begin
                reg_idx  = t_reg_idx'(k);
                reg_data = $urandom;
                case (reg_idx)
                    REG_CAPACITY_MJ: begin
                        case ($urandom_range(0, 7))
                            0: reg_data[CAP_W-1:0] = 16'd1;
                            1: reg_data[CAP_W-1:0] = 16'hFFFF;
                            2: reg_data[CAP_W-1:0] = 16'd0;
                            default: ;
                        endcase
                    end
                    // any level, upper bits dropped by the block
                    REG_THR_LOW, REG_THR_CRITICAL, REG_THR_URGENT: ;
                    default: begin
                        case ($urandom_range(0, 9))
                            0: reg_data = '0;
                            1: reg_data = '1;
                            default: reg_data = reg_data >> $urandom_range(8, 31);
                        endcase
                    end
                endcase
                write_reg(reg_idx, reg_data);
            end
            i_cfg_valid <= 1'b0;

            step_max = 1 << $urandom_range(0, 20);
            n_items  = SAMPLE_TARGET / PHASES + $urandom_range(0, 4);
            for (int s = 0; s < n_items; s++) begin
                // Mostly counting-up counters, sometimes a jump anywhere
                if ($urandom_range(0, 9) == 0)
                    run_ticks = {$urandom, $urandom, $urandom, $urandom};
                else
                    for (int c = 0; c < NUM_CNT; c++)
                        run_ticks[c] = run_ticks[c] + $urandom_range(0, step_max);
                send_sample(run_ticks, 1'b0, '0);
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 24) == 0) begin
                        wait_results_drained();
                    end else begin
                        s_axis_tvalid <= 1'b0;
                        repeat ($urandom_range(1, 40)) @(negedge i_clk);
                    end
                end
            end
        end

        // Drain, then allow stray beats to show up
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0 && pending_budget_q.size() == 0) begin
            $display("** energy_budget_tracker_core: PASSED **");
        end else begin
            $display("** energy_budget_tracker_core: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("** energy_budget_tracker_core: FAILED **");
        $finish;
    end

endmodule
